### hdl/slotalloc_pkg.sv
// Shared constants and codes for the slot allocator with descriptors.
// No dependencies; imported by the top level.
package slotalloc_pkg;

   localparam int DEF_SLOTS  = 32;   // default number of allocatable slots
   localparam int DESC_DEPTH = 32;   // descriptor tables, indexed by low id bits
   localparam int DESC_IDX_W = 5;
   localparam int ID_W       = 11;
   localparam int TABLE_ID_W = 10;
   localparam int REG_W      = 5;
   localparam int DATA_W     = 32;
   localparam int TAG_W      = 8;
   localparam int TYPE_W     = 4;
   localparam int PADDR_W    = 3;

   localparam logic [ID_W-1:0] ID_BASE = 11'h400;

   // register codes carried in reg_addr
   localparam logic [REG_W-1:0] REG_ALLOC = 5'd1;  // allocate, or set structure
   localparam logic [REG_W-1:0] REG_FREE  = 5'd2;  // free, or set type (memory read)

   // command codes
   localparam logic CMD_CONFIG = 1'b0;
   localparam logic CMD_REPLY  = 1'b1;

   // result kinds
   localparam logic KIND_ANSWER = 1'b0;
   localparam logic KIND_READ   = 1'b1;

   // CSR word index (paddr[2])
   localparam logic CSR_TABLE_ID = 1'b0;

endpackage

### hdl/slot_allocator_with_descriptors.sv
// Slot allocator with per-slot structure and type descriptors.
// Depends on slotalloc_pkg.
//
// Usage:
//  - Input channel: drive the req_* fields and raise start; a beat is taken at
//    the rising edge where start is high and busy is low. busy is high while
//    an allocation scans the in-use map.
//  - Result channel: a result beat sits on the rsp_* ports for exactly one
//    cycle, marked by rsp_strobe. The receiver cannot stall it, so take it then.
//  - CSR port: APB-style, one register (table_unit_id) at byte address 0.
//    pready is tied high. Write only while the block is idle.
//  - Answers: most requests answer in the cycle after the accepting edge and
//    busy stays low, so a new beat may follow straight away. An allocate walks
//    the in-use map one slot a cycle through a single compare unit; the answer
//    strobes in the cycle after the last scan step. busy is high throughout.
//  - A memory read request is a result beat with rsp_out_kind high; the block
//    then drops every request beat until a reply beat (req_command high)
//    arrives, stores it as the type descriptor and answers the request.
//  - Reset (synchronous): clears the in-use map, the pending read, the table
//    id and the sequencer. Descriptor tables hold garbage until written.
module slot_allocator_with_descriptors
   import slotalloc_pkg::*;
#(
   parameter int SLOTS = DEF_SLOTS
) (
   input  logic                  clock,
   input  logic                  reset,
   // input channel
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_command,
   input  logic [ID_W-1:0]       req_unit_id,
   input  logic [REG_W-1:0]      req_reg_addr,
   input  logic [DATA_W-1:0]     req_data,
   input  logic                  req_kind,
   input  logic [TAG_W-1:0]      req_tag,
   input  logic [DATA_W-1:0]     req_mem_data,
   // result channel
   output logic                  rsp_strobe,
   output logic                  rsp_out_kind,
   output logic [ID_W-1:0]       rsp_resp_id,
   output logic [ID_W-1:0]       rsp_resp_data,
   output logic                  rsp_resp_kind,
   output logic [TAG_W-1:0]      rsp_resp_tag,
   output logic [DATA_W-1:0]     rsp_mem_addr,
   // CSR port
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [PADDR_W-1:0]    paddr,
   input  logic [DATA_W-1:0]     pwdata,
   output logic [DATA_W-1:0]     prdata,
   output logic                  pready
);

   localparam int SLOT_W = $clog2(SLOTS);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);
   localparam logic [DESC_IDX_W:0] SLOTS_LIM = (DESC_IDX_W + 1)'(SLOTS);

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   // ---------------------------------------------------------------------
   // CSR: table unit id
   // ---------------------------------------------------------------------
   logic [TABLE_ID_W-1:0] table_id_ff;
   logic                  csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr[2] == CSR_TABLE_ID);

   always_ff @(posedge clock) begin
      if (reset) begin
         table_id_ff <= '0;
      end else if (csr_wr) begin
         table_id_ff <= pwdata[TABLE_ID_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_TABLE_ID) begin
         prdata = DATA_W'(table_id_ff);
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer registers
   // ---------------------------------------------------------------------
   state_type           state_ff, state_in;
   logic [SLOT_W-1:0]   idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [ID_W-1:0]     pend_id_ff, pend_id_in;
   logic                pend_kind_ff, pend_kind_in;
   logic [TAG_W-1:0]    pend_tag_ff, pend_tag_in;
   // request under allocation
   logic [ID_W-1:0]     job_id_ff, job_id_in;
   logic                job_kind_ff, job_kind_in;
   logic [TAG_W-1:0]    job_tag_ff, job_tag_in;
   logic [TYPE_W-1:0]   job_type_ff, job_type_in;
   // result registers
   logic                strobe_ff, strobe_in;
   logic                out_kind_ff, out_kind_in;
   logic [ID_W-1:0]     resp_id_ff, resp_id_in;
   logic [ID_W-1:0]     resp_data_ff, resp_data_in;
   logic                resp_kind_ff, resp_kind_in;
   logic [TAG_W-1:0]    resp_tag_ff, resp_tag_in;
   logic [DATA_W-1:0]   mem_addr_ff, mem_addr_in;

   // map and descriptor write controls
   logic                map_set, map_clr;
   logic [SLOT_W-1:0]   map_set_idx, map_clr_idx;
   logic                sdesc_we, tdesc_we;
   logic [DESC_IDX_W-1:0] sdesc_idx, tdesc_idx;

   logic [SLOTS-1:0]    in_use_ff;
   logic                accept;
   logic                slot_busy;
   logic [DESC_IDX_W-1:0] free_slot;

   assign accept    = start && !busy;
   assign busy      = (state_ff != ST_IDLE);
   // shared compare unit: one map entry tested per scan cycle
   assign slot_busy = in_use_ff[idx_ff];
   assign free_slot = req_data[DESC_IDX_W-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      pend_in      = pend_ff;
      pend_id_in   = pend_id_ff;
      pend_kind_in = pend_kind_ff;
      pend_tag_in  = pend_tag_ff;
      job_id_in    = job_id_ff;
      job_kind_in  = job_kind_ff;
      job_tag_in   = job_tag_ff;
      job_type_in  = job_type_ff;
      strobe_in    = 1'b0;
      out_kind_in  = KIND_ANSWER;
      resp_id_in   = resp_id_ff;
      resp_data_in = '0;
      resp_kind_in = resp_kind_ff;
      resp_tag_in  = resp_tag_ff;
      mem_addr_in  = '0;
      map_set      = 1'b0;
      map_clr      = 1'b0;
      map_set_idx  = idx_ff;
      map_clr_idx  = free_slot[SLOT_W-1:0];
      sdesc_we     = 1'b0;
      tdesc_we     = 1'b0;
      sdesc_idx    = req_unit_id[DESC_IDX_W-1:0];
      tdesc_idx    = pend_id_ff[DESC_IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (pend_ff) begin
                  // only a memory reply is taken; drop anything else
                  if (req_command == CMD_REPLY) begin
                     tdesc_we     = 1'b1;
                     pend_in      = 1'b0;
                     strobe_in    = 1'b1;
                     resp_id_in   = pend_id_ff;
                     resp_kind_in = pend_kind_ff;
                     resp_tag_in  = pend_tag_ff;
                  end
               end else if (req_command == CMD_CONFIG) begin
                  if (req_unit_id == ID_W'(table_id_ff)) begin
                     if (req_reg_addr == REG_ALLOC) begin
                        job_id_in   = req_unit_id;
                        job_kind_in = req_kind;
                        job_tag_in  = req_tag;
                        job_type_in = req_data[TYPE_W-1:0];
                        idx_in      = '0;
                        state_in    = ST_SCAN;
                     end else if (req_reg_addr == REG_FREE) begin
                        map_clr      = ({1'b0, free_slot} < SLOTS_LIM);
                        strobe_in    = 1'b1;
                        resp_id_in   = req_unit_id;
                        resp_kind_in = req_kind;
                        resp_tag_in  = req_tag;
                     end
                  end else if (req_unit_id[ID_W-1]) begin
                     if (req_reg_addr == REG_ALLOC) begin
                        sdesc_we     = 1'b1;
                        strobe_in    = 1'b1;
                        resp_id_in   = req_unit_id;
                        resp_kind_in = req_kind;
                        resp_tag_in  = req_tag;
                     end else if (req_reg_addr == REG_FREE) begin
                        // issue the read and park the request until the reply
                        pend_in      = 1'b1;
                        pend_id_in   = req_unit_id;
                        pend_kind_in = req_kind;
                        pend_tag_in  = req_tag;
                        strobe_in    = 1'b1;
                        out_kind_in  = KIND_READ;
                        resp_id_in   = '0;
                        resp_kind_in = 1'b0;
                        resp_tag_in  = '0;
                        mem_addr_in  = req_data;
                     end
                  end
               end
            end
         end
         ST_SCAN: begin
            if (!slot_busy) begin
               map_set      = 1'b1;
               strobe_in    = 1'b1;
               resp_id_in   = job_id_ff;
               resp_data_in = ID_BASE | ID_W'(idx_ff);
               resp_kind_in = job_kind_ff;
               resp_tag_in  = job_tag_ff;
               state_in     = ST_IDLE;
            end else if (idx_ff == LAST_SLOT) begin
               // map full: answer zero
               strobe_in    = 1'b1;
               resp_id_in   = job_id_ff;
               resp_kind_in = job_kind_ff;
               resp_tag_in  = job_tag_ff;
               state_in     = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pend_id_ff   <= pend_id_in;
      pend_kind_ff <= pend_kind_in;
      pend_tag_ff  <= pend_tag_in;
      job_id_ff    <= job_id_in;
      job_kind_ff  <= job_kind_in;
      job_tag_ff   <= job_tag_in;
      job_type_ff  <= job_type_in;
      out_kind_ff  <= out_kind_in;
      resp_id_ff   <= resp_id_in;
      resp_data_ff <= resp_data_in;
      resp_kind_ff <= resp_kind_in;
      resp_tag_ff  <= resp_tag_in;
      mem_addr_ff  <= mem_addr_in;
      if (reset) begin
         state_ff  <= ST_IDLE;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_out_kind  = out_kind_ff;
   assign rsp_resp_id   = resp_id_ff;
   assign rsp_resp_data = resp_data_ff;
   assign rsp_resp_kind = resp_kind_ff;
   assign rsp_resp_tag  = resp_tag_ff;
   assign rsp_mem_addr  = mem_addr_ff;

   // ---------------------------------------------------------------------
   // In-use map: one flop per slot, cleared at reset
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else begin
         if (map_set) begin
            in_use_ff[map_set_idx] <= 1'b1;
         end
         if (map_clr) begin
            in_use_ff[map_clr_idx] <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Descriptor stores: write-only here, undefined until written
   // ---------------------------------------------------------------------
   logic [TYPE_W-1:0] slot_type_mem [SLOTS];
   logic [DATA_W-1:0] sdesc_mem [DESC_DEPTH];
   logic [DATA_W-1:0] tdesc_mem [DESC_DEPTH];

   always_ff @(posedge clock) begin
      if (map_set) begin
         slot_type_mem[map_set_idx] <= job_type_ff;
      end
      if (sdesc_we) begin
         sdesc_mem[sdesc_idx] <= req_data;
      end
      if (tdesc_we) begin
         tdesc_mem[tdesc_idx] <= req_mem_data;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_pend_blocks_scan : assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> (state_ff == ST_IDLE))
      else $error("allocation scan running while a read is pending");

   a_read_sets_pend : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_out_kind == KIND_READ) |-> pend_ff)
      else $error("memory read issued without a pending record");

   a_alloc_marks_map : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_resp_data != '0) |-> in_use_ff[rsp_resp_data[SLOT_W-1:0]])
      else $error("allocated slot not marked in use");

   a_scan_in_range : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= LAST_SLOT))
      else $error("scan index beyond the last slot");

endmodule

### test/tb_slot_allocator_with_descriptors.sv
`timescale 1ns / 100ps
// Self-checking testbench for slot_allocator_with_descriptors: directed corner beats, then
// random allocate/free/descriptor traffic checked against a predictor of the slot map.
// Depends on slotalloc_pkg and the block's RTL only.
module tb_slot_allocator_with_descriptors
   import slotalloc_pkg::*;
();

   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE      = DEF_SLOTS + 4;   // longest allocate scan plus slack

   // register codes the block does not decode
   localparam logic [REG_W-1:0] REG_NONE  = 5'd0;
   localparam logic [REG_W-1:0] REG_SPARE = 5'd3;
   localparam logic [REG_W-1:0] REG_TOP   = 5'd31;

   typedef struct packed {
      logic              command;
      logic [ID_W-1:0]   unit_id;
      logic [REG_W-1:0]  reg_addr;
      logic [DATA_W-1:0] data;
      logic              kind;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] mem_data;
   } beat_type;

   typedef struct packed {
      logic              out_kind;
      logic [ID_W-1:0]   id;
      logic [ID_W-1:0]   data;
      logic              kind;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] mem_addr;
   } answer_type;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   logic              req_command;
   logic [ID_W-1:0]   req_unit_id;
   logic [REG_W-1:0]  req_reg_addr;
   logic [DATA_W-1:0] req_data;
   logic              req_kind;
   logic [TAG_W-1:0]  req_tag;
   logic [DATA_W-1:0] req_mem_data;
   logic              rsp_strobe;
   logic              rsp_out_kind;
   logic [ID_W-1:0]   rsp_resp_id;
   logic [ID_W-1:0]   rsp_resp_data;
   logic              rsp_resp_kind;
   logic [TAG_W-1:0]  rsp_resp_tag;
   logic [DATA_W-1:0] rsp_mem_addr;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [PADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   // Predictor state: what the block should hold after every accepted beat.
   logic [DEF_SLOTS-1:0]  slots_held;
   logic [TABLE_ID_W-1:0] table_id;
   bit                    read_waiting;
   logic [ID_W-1:0]       waiting_id;
   logic                  waiting_kind;
   logic [TAG_W-1:0]      waiting_tag;

   answer_type answers_due[$];   // answers still to come, oldest first

   bit gapless;               // when set, the sender offers beats back to back
   int cycle_count       = 0;
   int mismatches        = 0;
   int beats_sent        = 0;
   int answers_predicted = 0;
   int answers_checked   = 0;
   int slots_granted     = 0;
   int full_refusals     = 0;
   int reads_issued      = 0;
   int beats_dropped     = 0;

   slot_allocator_with_descriptors dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_command   (req_command),
      .req_unit_id   (req_unit_id),
      .req_reg_addr  (req_reg_addr),
      .req_data      (req_data),
      .req_kind      (req_kind),
      .req_tag       (req_tag),
      .req_mem_data  (req_mem_data),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_resp_id   (rsp_resp_id),
      .rsp_resp_data (rsp_resp_data),
      .rsp_resp_kind (rsp_resp_kind),
      .rsp_resp_tag  (rsp_resp_tag),
      .rsp_mem_addr  (rsp_mem_addr),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // Watchdog: a hung handshake or a lost answer ends the run here.
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAILURE");
      $finish;
   end

   // Work out the answer that one accepted beat causes, if any, and advance the
   // predictor state. A pending memory read swallows everything but a reply.
   task automatic predict_answer(input beat_type b);
      answer_type a;
      bit      answered;
      bit      found;
      int      s;
      a        = '0;
      answered = 1'b0;
      found    = 1'b0;
      if (read_waiting) begin
         if (b.command == CMD_REPLY) begin
            // the reply completes the held request; the answer echoes it
            a.out_kind   = KIND_ANSWER;
            a.id         = waiting_id;
            a.kind       = waiting_kind;
            a.tag        = waiting_tag;
            read_waiting = 1'b0;
            answered     = 1'b1;
         end
      end else if (b.command == CMD_CONFIG) begin
         if (b.unit_id == {1'b0, table_id}) begin
            a.out_kind = KIND_ANSWER;
            a.id       = b.unit_id;
            a.kind     = b.kind;
            a.tag      = b.tag;
            if (b.reg_addr == REG_ALLOC) begin
               // lowest free slot wins; a full map answers zero
               for (s = 0; s < DEF_SLOTS && !found; s++) begin
                  if (!slots_held[s]) begin
                     slots_held[s] = 1'b1;
                     a.data        = ID_BASE | ID_W'(s);
                     found         = 1'b1;
                  end
               end
               if (found) slots_granted++;
               else full_refusals++;
               answered = 1'b1;
            end else if (b.reg_addr == REG_FREE) begin
               s = int'(b.data[DESC_IDX_W-1:0]);
               if (s < DEF_SLOTS) slots_held[s] = 1'b0;
               answered = 1'b1;
            end
         end else if (b.unit_id >= ID_BASE) begin
            if (b.reg_addr == REG_ALLOC) begin
               a.out_kind = KIND_ANSWER;
               a.id       = b.unit_id;
               a.kind     = b.kind;
               a.tag      = b.tag;
               answered   = 1'b1;
            end else if (b.reg_addr == REG_FREE) begin
               // issue a memory read and hold the request until its reply
               a.out_kind   = KIND_READ;
               a.mem_addr   = b.data;
               read_waiting = 1'b1;
               waiting_id   = b.unit_id;
               waiting_kind = b.kind;
               waiting_tag  = b.tag;
               reads_issued++;
               answered     = 1'b1;
            end
         end
      end
      if (answered) begin
         answers_due.push_back(a);
         answers_predicted++;
      end else begin
         beats_dropped++;
      end
   endtask

   // Offer one beat after a random gap and hold it until the block takes it.
   // Leaves start high on return, so the caller either sends again at once or
   // lowers start in the same step.
   task automatic send_beat(input beat_type b);
      int gap;
      gap = gapless ? 0 : $urandom_range(4, 0);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start        <= 1'b1;
      req_command  <= b.command;
      req_unit_id  <= b.unit_id;
      req_reg_addr <= b.reg_addr;
      req_data     <= b.data;
      req_kind     <= b.kind;
      req_tag      <= b.tag;
      req_mem_data <= b.mem_data;
      @(posedge clock);
      while (busy) @(posedge clock);
      predict_answer(b);
      beats_sent++;
   endtask

   // Stop offering beats, wait for every outstanding answer, then linger.
   task automatic settle(input int linger);
      start <= 1'b0;
      @(posedge clock);
      while (answers_due.size() != 0) @(posedge clock);
      repeat (linger) @(posedge clock);
   endtask

   // Write the table id over the CSR port with the block idle, then read it back.
   task automatic write_table_id(input logic [TABLE_ID_W-1:0] value);
      logic [DATA_W-1:0] readback;
      if (read_waiting)
         send_beat({CMD_REPLY, ID_W'($urandom), REG_W'($urandom), DATA_W'($urandom),
                    1'($urandom), TAG_W'($urandom), DATA_W'($urandom)});
      settle(SETTLE);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {CSR_TABLE_ID, 2'b00};
      pwdata  <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      table_id = value;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      readback = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      if (readback[TABLE_ID_W-1:0] !== value) begin
         $error("table_unit_id: expected 0x%0h, got 0x%0h", value, readback);
         mismatches++;
      end
   endtask

   function automatic beat_type make_beat(input logic cmd, input logic [ID_W-1:0] id,
                                          input logic [REG_W-1:0] addr,
                                          input logic [DATA_W-1:0] data, input logic kind,
                                          input logic [TAG_W-1:0] tag,
                                          input logic [DATA_W-1:0] mem);
      beat_type b;
      b = {cmd, id, addr, data, kind, tag, mem};
      return b;
   endfunction

   // Prefer a slot that is currently held, so descriptor and free traffic hits live slots.
   function automatic int pick_live_slot();
      int slot;
      int tries;
      slot = $urandom_range(DEF_SLOTS - 1, 0);
      for (tries = 0; tries < 16 && !slots_held[slot]; tries++)
         slot = $urandom_range(DEF_SLOTS - 1, 0);
      return slot;
   endfunction

   // Draw a beat: mostly well-formed traffic in the given mix, the rest stray
   // replies and noise. While a read is pending, mostly send its reply.
   function automatic beat_type random_beat(input int alloc_pct, input int free_pct,
                                            input int desc_pct);
      beat_type b;
      int    roll;
      b.command  = CMD_CONFIG;
      b.unit_id  = ID_W'($urandom);
      b.reg_addr = REG_W'($urandom);
      b.data     = $urandom;
      b.kind     = 1'($urandom);
      b.tag      = TAG_W'($urandom);
      b.mem_data = $urandom;
      roll       = $urandom_range(99, 0);
      if (read_waiting) begin
         if (roll < 80) begin
            b.command = CMD_REPLY;
         end else if (roll < 90) begin
            b.unit_id  = {1'b0, table_id};
            b.reg_addr = REG_ALLOC;
         end
      end else if (roll < alloc_pct) begin
         b.unit_id  = {1'b0, table_id};
         b.reg_addr = REG_ALLOC;
      end else if (roll < alloc_pct + free_pct) begin
         b.unit_id  = {1'b0, table_id};
         b.reg_addr = REG_FREE;
         if ($urandom_range(4, 0) != 0)
            b.data[DESC_IDX_W-1:0] = DESC_IDX_W'(pick_live_slot());
      end else if (roll < alloc_pct + free_pct + desc_pct) begin
         b.unit_id                 = b.unit_id | ID_BASE;
         b.unit_id[DESC_IDX_W-1:0] = DESC_IDX_W'(pick_live_slot());
         b.reg_addr                = $urandom_range(1, 0) ? REG_ALLOC : REG_FREE;
      end else if ($urandom_range(1, 0)) begin
         b.command = CMD_REPLY;   // reply with nothing pending
      end else if ($urandom_range(1, 0)) begin
         b.unit_id = {1'b0, table_id};   // random register on the table unit
      end
      return b;
   endfunction

   // Run random beats until the given number of answers has been predicted.
   task automatic run_random(input int answers, input int alloc_pct, input int free_pct,
                             input int desc_pct);
      int first;
      int n;
      first = answers_predicted;
      n     = 0;
      while (answers_predicted - first < answers) begin
         if (n % 64 == 0) gapless = ($urandom_range(3, 0) == 0);
         send_beat(random_beat(alloc_pct, free_pct, desc_pct));
         n++;
      end
      gapless = 1'b0;
   endtask

   // Corner beats with the table id at its reset value of zero.
   task automatic test_directed_corners();
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_ALLOC, 32'hFFFF_FFFF, 1'b1, 8'hFF, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_ALLOC, 32'h0, 1'b0, 8'h00, 32'hFFFF_FFFF));
      send_beat(make_beat(CMD_CONFIG, 11'h7FF, REG_ALLOC, 32'hFFFF_FFFF, 1'b0, 8'h5A, 32'h0));
      send_beat(make_beat(CMD_CONFIG, ID_BASE, REG_ALLOC, 32'h0, 1'b1, 8'h01, 32'h0));
      // memory read, a request dropped while it waits, then the reply
      send_beat(make_beat(CMD_CONFIG, 11'h401, REG_FREE, 32'hFFFF_FFFF, 1'b1, 8'hA5, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_ALLOC, 32'h0, 1'b0, 8'h11, 32'h0));
      send_beat(make_beat(CMD_REPLY, 11'h7FF, REG_TOP, 32'hFFFF_FFFF, 1'b0, 8'h22,
                          32'hFFFF_FFFF));
      // reply with nothing pending is dropped
      send_beat(make_beat(CMD_REPLY, 11'd0, REG_ALLOC, 32'h0, 1'b1, 8'h33, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'h7FF, REG_FREE, 32'h0, 1'b0, 8'hFF, 32'h0));
      send_beat(make_beat(CMD_REPLY, 11'h400, REG_NONE, 32'h0, 1'b1, 8'h00, 32'h0));
      // free slot zero, free it again, free a slot that was never held
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_FREE, 32'h0, 1'b1, 8'h44, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_FREE, 32'h0, 1'b0, 8'h45, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_FREE, 32'hFFFF_FFFF, 1'b1, 8'h46, 32'h0));
      // the freed lowest slot is handed out again
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_ALLOC, 32'h0000_0007, 1'b0, 8'h47, 32'h0));
      // unknown registers and unknown ids give no answer
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_NONE, 32'h0, 1'b1, 8'h50, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_TOP, 32'hFFFF_FFFF, 1'b0, 8'h51, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'h406, REG_SPARE, 32'h0, 1'b1, 8'h52, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'h3FF, REG_ALLOC, 32'h0, 1'b0, 8'h53, 32'h0));
      send_beat(make_beat(CMD_CONFIG, 11'd5, REG_FREE, 32'h0, 1'b1, 8'h54, 32'h0));
      // slot picked from the low bits of a wide data word
      send_beat(make_beat(CMD_CONFIG, 11'd0, REG_FREE, 32'hFFFF_FFE1, 1'b0, 8'h55, 32'h0));
   endtask

   // Swing the map between full and empty so refusals and reuse both show up.
   task automatic test_allocation_churn();
      int k;
      for (k = 0; k < 4; k++) begin
         run_random(90, 65, 15, 10);
         run_random(90, 15, 60, 10);
      end
   endtask

   task automatic test_descriptor_traffic();
      run_random(500, 15, 10, 60);
   endtask

   // Mixed traffic with plenty of noise; hold off at least once until all has come back.
   task automatic test_mixed_noise();
      int k;
      for (k = 0; k < 4; k++) begin
         run_random(130, 25, 20, 30);
         if (k == 1 || $urandom_range(2, 0) == 0) settle(0);
      end
   endtask

   // Take each answer beat in the cycle it is shown and compare it with the oldest
   // expectation.
   task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_strobe) begin
         answers_checked++;
         if (answers_due.size() == 0) begin
            $error("answer beat with nothing outstanding: id 0x%0h data 0x%0h",
                   rsp_resp_id, rsp_resp_data);
            mismatches++;
         end else begin
            want = answers_due.pop_front();
            check_field("out_kind", DATA_W'(want.out_kind), DATA_W'(rsp_out_kind));
            check_field("resp_id", DATA_W'(want.id), DATA_W'(rsp_resp_id));
            check_field("resp_data", DATA_W'(want.data), DATA_W'(rsp_resp_data));
            check_field("resp_kind", DATA_W'(want.kind), DATA_W'(rsp_resp_kind));
            check_field("resp_tag", DATA_W'(want.tag), DATA_W'(rsp_resp_tag));
            check_field("mem_addr", want.mem_addr, rsp_mem_addr);
         end
      end
   end

   initial begin
      // drive every input to a known value before the first edge
      reset        <= 1'b1;
      start        <= 1'b0;
      req_command  <= CMD_CONFIG;
      req_unit_id  <= '0;
      req_reg_addr <= REG_NONE;
      req_data     <= '0;
      req_kind     <= 1'b0;
      req_tag      <= '0;
      req_mem_data <= '0;
      psel         <= 1'b0;
      penable      <= 1'b0;
      pwrite       <= 1'b0;
      paddr        <= '0;
      pwdata       <= '0;
      slots_held   = '0;
      table_id     = '0;
      read_waiting = 1'b0;
      waiting_id   = '0;
      waiting_kind = 1'b0;
      waiting_tag  = '0;
      gapless      = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      write_table_id(10'h3FF);
      test_allocation_churn();
      write_table_id(TABLE_ID_W'($urandom_range(1022, 1)));
      test_descriptor_traffic();
      write_table_id(10'h000);
      test_mixed_noise();

      // drain: every expectation must be met, then allow for a full scan
      start <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);

      $display("Sent %0d request beats (%0d dropped); checked %0d answers.",
               beats_sent, beats_dropped, answers_checked);
      $display("Granted %0d slots, refused %0d on a full map, issued %0d memory reads.",
               slots_granted, full_refusals, reads_issued);
      if (mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
